### rtl/ptue_pkg.sv
// Shared types and constants for the particle table update engine.
package ptue_pkg;

    typedef enum logic [1:0] {
        MODE_SPAWN  = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_SPARE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CHK,
        S_TK_RD,
        S_TK_CHK,
        S_TK_CALC,
        S_TK_WR,
        S_MV_RD,
        S_MV_WR
    } t_state;

    typedef enum logic [2:0] {
        RK_DONE,
        RK_SPAWN,
        RK_FULL,
        RK_MISS,
        RK_FOUND
    } t_res_kind;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] pos_xy;
        logic [63:0] vel_xy;
        logic [63:0] acc_xy;
        logic [63:0] size_xy;
        logic [30:0] time_value;
        logic [31:0] rgba;
        logic        outlined;
        logic [31:0] lookup_id;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] particle_id;
        logic [63:0] cur_pos_xy;
        logic [63:0] cur_vel_xy;
        logic [63:0] cur_size_xy;
        logic [30:0] time_left;
        logic [31:0] cur_rgba;
        logic        cur_outlined;
        logic [8:0]  live_count;
    } t_result;

    typedef struct packed {
        logic [31:0] ident;
        logic [63:0] pos;
        logic [63:0] vel;
        logic [63:0] acc;
        logic [63:0] ext;
        logic [30:0] rem;
        logic [30:0] span;
        logic [7:0]  base;
        logic [31:0] tint;
        logic        halo;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
    localparam logic [3:0] CALC_STEPS = 4'd8;

    typedef struct packed {
        logic      ld_item;
        logic      spawn;
        logic      clear;
        logic      idx_clr;
        logic      idx_inc;
        logic      live_dec;
        logic      rd_idx;
        logic      rd_last;
        logic      wr_move;
        logic      wr_upd;
        logic      calc_init;
        logic      calc_step;
        logic      resp;
        t_res_kind res_kind;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic idx_end;
        logic id_hit;
        logic dead;
        logic last_is_idx;
        logic calc_done;
    } t_stat;

endpackage

### rtl/ptue_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

### rtl/ptue_ctrl.sv
// Controller state machine sequencing spawn, tick, lookup and clear items.
module ptue_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_mode,
    input  ptue_pkg::t_stat i_stat,
    output ptue_pkg::t_cmd  o_cmd,
    output logic            busy,
    output logic            o_done
);
    import ptue_pkg::*;

    t_state r_state, n_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.resp;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_kind = RK_DONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.ld_item = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    unique case (t_mode'(i_mode))
                        MODE_SPAWN: begin
                            o_cmd.resp = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.res_kind = RK_FULL;
                            end else begin
                                o_cmd.spawn    = 1'b1;
                                o_cmd.res_kind = RK_SPAWN;
                            end
                        end
                        MODE_TICK:   n_state = S_TK_RD;
                        MODE_LOOKUP: n_state = S_LK_RD;
                        MODE_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            o_cmd.resp  = 1'b1;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LK_RD: begin
                if (i_stat.idx_end) begin
                    o_cmd.resp     = 1'b1;
                    o_cmd.res_kind = RK_MISS;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_LK_CHK;
                end
            end
            S_LK_CHK: begin
                if (i_stat.id_hit) begin
                    o_cmd.resp     = 1'b1;
                    o_cmd.res_kind = RK_FOUND;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_LK_RD;
                end
            end
            S_TK_RD: begin
                if (i_stat.idx_end) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_TK_CHK;
                end
            end
            S_TK_CHK: begin
                if (i_stat.dead) begin
                    o_cmd.live_dec = 1'b1;
                    n_state = i_stat.last_is_idx ? S_TK_RD : S_MV_RD;
                end else begin
                    o_cmd.calc_init = 1'b1;
                    n_state         = S_TK_CALC;
                end
            end
            S_TK_CALC: begin
                if (i_stat.calc_done) begin
                    n_state = S_TK_WR;
                end else begin
                    o_cmd.calc_step = 1'b1;
                end
            end
            S_TK_WR: begin
                o_cmd.wr_upd  = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_TK_RD;
            end
            S_MV_RD: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_MV_WR;
            end
            S_MV_WR: begin
                o_cmd.wr_move = 1'b1;
                n_state       = S_TK_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### rtl/ptue_dpath.sv
// Datapath: particle table, counters, Euler step, alpha divider and result register.
module ptue_dpath #(
    parameter int MAX_PARTICLES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptue_pkg::t_item   i_item,
    input  ptue_pkg::t_cmd    i_cmd,
    output ptue_pkg::t_stat   o_stat,
    output ptue_pkg::t_result o_result
);
    import ptue_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_PARTICLES);

    logic [CW-1:0]  r_live, n_live, r_idx;
    logic [31:0]    r_idc;
    t_item          r_item;
    t_entry         r_ent, rd_ent, wr_ent, spawn_ent, upd_ent;
    t_result        r_res;
    logic [ENTRY_W-1:0] ram_rdata;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;

    logic signed [31:0] rem_next;
    logic [38:0]    num_full;
    logic [30:0]    r_rem_new;
    logic [38:0]    r_num;
    logic           r_satq, r_zero;
    logic [7:0]     r_q;
    logic [3:0]     r_step;
    logic signed [63:0] r_prod;
    logic [63:0]    r_npos, r_nvel;

    logic [1:0]     comp;
    logic signed [31:0] op_base, op_rate, dt_s;
    logic signed [63:0] prod, prod_sh;
    logic signed [48:0] sum;
    logic [31:0]    sat_v;
    logic [38:0]    trial;
    logic           ge;
    logic [7:0]     alpha;

    ptue_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARTICLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_ent),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = t_entry'(ram_rdata);

    always_comb begin
        spawn_ent.ident = r_idc;
        spawn_ent.pos   = i_item.pos_xy;
        spawn_ent.vel   = i_item.vel_xy;
        spawn_ent.acc   = i_item.acc_xy;
        spawn_ent.ext   = i_item.size_xy;
        spawn_ent.rem   = i_item.time_value;
        spawn_ent.span  = i_item.time_value;
        spawn_ent.base  = i_item.rgba[7:0];
        spawn_ent.tint  = i_item.rgba;
        spawn_ent.halo  = i_item.outlined;
    end

    always_comb begin
        alpha = r_zero ? 8'd0 : (r_satq ? 8'hFF : r_q);
        upd_ent      = r_ent;
        upd_ent.pos  = r_npos;
        upd_ent.vel  = r_nvel;
        upd_ent.rem  = r_rem_new;
        upd_ent.tint = {r_ent.tint[31:8], alpha};
    end

    always_comb begin
        ram_we    = i_cmd.spawn | i_cmd.wr_move | i_cmd.wr_upd;
        ram_waddr = i_cmd.spawn ? r_live[AW-1:0] : r_idx[AW-1:0];
        wr_ent    = i_cmd.spawn ? spawn_ent : (i_cmd.wr_move ? rd_ent : upd_ent);
        ram_re    = i_cmd.rd_idx | i_cmd.rd_last;
        ram_raddr = i_cmd.rd_last ? r_live[AW-1:0] : r_idx[AW-1:0];
    end

    assign rem_next = $signed({1'b0, rd_ent.rem}) - $signed({1'b0, r_item.time_value});
    assign num_full = 39'(rd_ent.base) * 39'(rem_next[30:0]);

    // Euler step: even steps multiply, odd steps add and saturate; also forms the alpha divider trial
    always_comb begin
        comp = r_step[2:1];
        unique case (comp)
            2'd0: begin op_base = r_ent.pos[63:32]; op_rate = r_ent.vel[63:32]; end
            2'd1: begin op_base = r_ent.pos[31:0];  op_rate = r_ent.vel[31:0];  end
            2'd2: begin op_base = r_ent.vel[63:32]; op_rate = r_ent.acc[63:32]; end
            default: begin op_base = r_ent.vel[31:0]; op_rate = r_ent.acc[31:0]; end
        endcase
        dt_s    = $signed({1'b0, r_item.time_value});
        prod    = op_rate * dt_s;
        prod_sh = r_prod >>> 16;
        sum     = 49'(op_base) + prod_sh[48:0];
        if (sum > 49'sh0_7FFF_FFFF) begin
            sat_v = 32'h7FFF_FFFF;
        end else if (sum < -49'sh0_8000_0000) begin
            sat_v = 32'h8000_0000;
        end else begin
            sat_v = sum[31:0];
        end
        trial = 39'({r_ent.span, 7'd0}) >> r_step[2:0];
        ge    = (r_num >= trial);
    end

    always_comb begin
        n_live = r_live;
        if (i_cmd.clear) begin
            n_live = '0;
        end else if (i_cmd.spawn) begin
            n_live = r_live + 1'b1;
        end else if (i_cmd.live_dec) begin
            n_live = r_live - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
            r_idc  <= '0;
            r_idx  <= '0;
            r_step <= '0;
        end else begin
            r_live <= n_live;
            if (i_cmd.spawn) begin
                r_idc <= r_idc + 32'd1;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.calc_init) begin
                r_step <= '0;
            end else if (i_cmd.calc_step) begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_item <= i_item;
        end
        if (i_cmd.calc_init) begin
            r_ent     <= rd_ent;
            r_rem_new <= rem_next[30:0];
            r_num     <= num_full;
            r_satq    <= (num_full >= 39'({rd_ent.span, 8'd0}));
            r_zero    <= (rd_ent.span == '0);
        end
        if (i_cmd.calc_step) begin
            if (!r_step[0]) begin
                r_prod <= prod;
            end else begin
                unique case (comp)
                    2'd0: r_npos[63:32] <= sat_v;
                    2'd1: r_npos[31:0]  <= sat_v;
                    2'd2: r_nvel[63:32] <= sat_v;
                    default: r_nvel[31:0] <= sat_v;
                endcase
            end
            r_q <= {r_q[6:0], ge};
            if (ge) begin
                r_num <= r_num - trial;
            end
        end
        if (i_cmd.resp) begin
            r_res            <= '0;
            r_res.live_count <= 9'(n_live);
            unique case (i_cmd.res_kind)
                RK_SPAWN: r_res.particle_id <= r_idc;
                RK_FULL:  r_res.status      <= ST_FULL;
                RK_MISS:  r_res.status      <= ST_MISS;
                RK_FOUND: begin
                    r_res.particle_id  <= rd_ent.ident;
                    r_res.cur_pos_xy   <= rd_ent.pos;
                    r_res.cur_vel_xy   <= rd_ent.vel;
                    r_res.cur_size_xy  <= rd_ent.ext;
                    r_res.time_left    <= rd_ent.rem;
                    r_res.cur_rgba     <= rd_ent.tint;
                    r_res.cur_outlined <= rd_ent.halo;
                end
                default: r_res.status <= ST_OK;
            endcase
        end
    end

    always_comb begin
        o_stat.full        = (r_live >= MAX_C);
        o_stat.idx_end     = (r_idx >= r_live);
        o_stat.id_hit      = (rd_ent.ident == r_item.lookup_id);
        o_stat.dead        = rem_next[31] | (rem_next == 32'sd0);
        o_stat.last_is_idx = ((r_live - 1'b1) == r_idx);
        o_stat.calc_done   = (r_step == CALC_STEPS);
    end

    assign o_result = r_res;
endmodule

### rtl/particle_table_update_engine_core.sv
// Top level of the particle table update engine.
// An item is taken when start is high and busy is low; its fields arrive on
// i_item. Exactly one result follows on o_result, marked by o_done for one
// cycle; the receiver cannot hold it off, and busy is low in that cycle.
// Spawn and clear answer in the cycle after the item is taken.
// Lookup scans the table entry by entry, reading each one and then comparing
// its ID, until a hit or the end of the live entries.
// Tick visits every live particle: a surviving one is read, compared, put
// through eight shared-multiplier and divider steps and written back; a
// removed one is dropped, and unless it was the last entry the last entry is
// moved into its slot. The alpha divider gives one quotient bit per cycle.
// Reset empties the table and zeroes the ID counter at once; entries are
// never read before they are written, so no clearing pass is run.
module particle_table_update_engine_core #(
    parameter int MAX_PARTICLES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ptue_pkg::t_item   i_item,
    output logic              o_done,
    output ptue_pkg::t_result o_result
);
    import ptue_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ptue_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_item.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    ptue_dpath #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while engine busy");
    a_quick_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.mode == MODE_SPAWN || i_item.mode == MODE_CLEAR))
        |=> o_done)
        else $error("spawn or clear did not answer next cycle");
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_result.live_count) <= MAX_PARTICLES))
        else $error("live count above table depth");
    a_full_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> (o_result.particle_id == 32'd0))
        else $error("full status carries an id");
`endif
endmodule
